// ----- rtl/core/dlr_pkg.sv -----
// Shared types and constants for the delimited line receiver.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dlr_pkg;

  localparam int BUF_SIZE    = 32;
  localparam int CNT_W       = 6;
  localparam int ADDR_W      = $clog2(BUF_SIZE);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] START_CHAR_RESET = 8'h2A;
  localparam logic [7:0] END_CHAR_RESET   = 8'h0D;

  localparam logic REG_START_CHAR = 1'b0;
  localparam logic REG_END_CHAR   = 1'b1;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
    logic       line_pending;
  } out_item_t;

  // One classified received byte, as handed from front to back
  typedef struct packed {
    logic [7:0]        value;
    logic              store_en;
    logic [ADDR_W-1:0] store_addr;
    logic              handover;
    logic [CNT_W-1:0]  line_len;
    logic              pending;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_LINE,
    B_TERM
  } back_state_t;

endpackage

// ----- rtl/core/dlr_queue.sv -----
// Short request queue between the front and the back of the line receiver.
// Depends on dlr_pkg for the job type and depth.
`timescale 1ns / 1ps

module dlr_queue
  import dlr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_data,
  input  logic      pop,
  output job_t      head,
  output q_status_t status
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign status.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/dlr_front.sv -----
// Front of the line receiver: configuration, fill count, pending flag and
// classification of each request. Depends on dlr_pkg.
`timescale 1ns / 1ps

module dlr_front
  import dlr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [7:0] cfg_data,
  input  q_status_t q_status,
  output logic      push,
  output job_t      push_data
);

  logic [7:0]       start_char;
  logic [7:0]       end_char;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;
  logic             pending;
  logic             pending_next;
  logic             accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (in_data.cmd == CMD_BYTE);

  always_comb begin
    push_data            = '0;
    push_data.value      = in_data.rx_byte;
    push_data.store_addr = fill_count[ADDR_W-1:0];
    push_data.line_len   = fill_count;
    fill_count_next      = fill_count;
    pending_next         = pending;
    if (in_data.cmd == CMD_RELEASE) begin
      pending_next = 1'b0;
    end else if (in_data.rx_byte == start_char) begin
      fill_count_next = '0;
    end else if (in_data.rx_byte == end_char) begin
      if (!pending) begin
        push_data.handover = 1'b1;
        pending_next       = 1'b1;
      end
      fill_count_next = '0;
    end else if (fill_count < CNT_W'(BUF_SIZE - 1)) begin
      push_data.store_en = 1'b1;
      fill_count_next    = fill_count + 1'b1;
    end
    push_data.pending = pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= START_CHAR_RESET;
      end_char   <= END_CHAR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_CHAR: start_char <= cfg_data;
        REG_END_CHAR:   end_char   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      pending    <= 1'b0;
    end else if (accept) begin
      fill_count <= fill_count_next;
      pending    <= pending_next;
    end
  end

endmodule

// ----- rtl/core/dlr_back.sv -----
// Back of the line receiver: line store, echo and line hand-over sequencer,
// output register. Depends on dlr_pkg.
`timescale 1ns / 1ps

module dlr_back
  import dlr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  job_t      head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [7:0]        line_store [BUF_SIZE];
  logic [7:0]        rd_data;
  logic              rd_en;
  logic              mem_we;
  back_state_t       state;
  back_state_t       state_next;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  line_len;
  logic              line_pend;
  logic              out_free;
  logic              emit;
  out_item_t         emit_item;
  logic              idx_inc;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_status.empty && out_free && head.handover) begin
          state_next = B_FETCH;
        end
      end
      B_FETCH: begin
        state_next = (idx == line_len) ? B_TERM : B_LINE;
      end
      B_LINE: begin
        if (rd_data == 8'h00) begin
          state_next = B_TERM;
        end else if (out_free) begin
          state_next = B_FETCH;
        end
      end
      B_TERM: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    emit_item = '0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    idx_inc   = 1'b0;
    case (state)
      B_IDLE: begin
        if (!q_status.empty && out_free) begin
          pop       = 1'b1;
          emit      = 1'b1;
          emit_item = '{kind: KIND_ECHO, value: head.value, last: !head.handover,
                        line_pending: head.pending};
          mem_we    = head.store_en;
        end
      end
      B_FETCH: begin
        rd_en = (idx != line_len);
      end
      B_LINE: begin
        if (rd_data != 8'h00 && out_free) begin
          emit      = 1'b1;
          emit_item = '{kind: KIND_LINE, value: rd_data, last: 1'b0,
                        line_pending: line_pend};
          idx_inc   = 1'b1;
        end
      end
      B_TERM: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_item = '{kind: KIND_LINE, value: 8'h00, last: 1'b1,
                        line_pending: line_pend};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[head.store_addr] <= head.value;
    end
    if (rd_en) begin
      rd_data <= line_store[idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      line_len  <= head.line_len;
      line_pend <= head.pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (pop) begin
        idx <= '0;
      end else if (idx_inc) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_item;
    end
  end

endmodule

// ----- rtl/core/delimited_line_receiver.sv -----
// Top level of the delimited line receiver: front, request queue and back.
// Depends on dlr_pkg, dlr_front, dlr_queue and dlr_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   in       | in_valid / in_ready  | in_data  (cmd, rx_byte)
//   out      | out_valid / out_ready| out_data (kind, value, last, line_pending)
//   cfg      | cfg_we               | cfg_index, cfg_data
//
// A received byte gives its echo through the queue and the output register
// when the back is idle and the output free. After the echo, a handed-over
// line is sent up to its length or a zero byte, plus a terminator, through the
// registered read port of the line store; the front keeps taking requests
// until the four-entry queue fills. Reset clears the counts, the pending flag
// and the queue and restores the delimiters; the line store is not cleared.
// A stalled output holds the back, which then stops draining the queue.
`timescale 1ns / 1ps

module delimited_line_receiver
  import dlr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  q_status_t q_status;
  logic      push;
  job_t      push_data;
  logic      pop;
  job_t      head;

  dlr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  dlr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  dlr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_line_byte_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_LINE && !out_data.last |-> out_data.value != 8'h00)
    else $error("line byte before terminator is zero");

  a_open_echo_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_ECHO && !out_data.last |-> out_data.line_pending)
    else $error("echo opening a hand-over without pending flag");

  a_line_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_LINE |-> out_data.line_pending)
    else $error("line result without pending flag");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("queue popped while empty");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for delimited_line_receiver: directed lines, then random traffic.
// Needs dlr_pkg and the block RTL; predicts echoes and handed-over lines per request.
`timescale 1ns / 1ps

module tb;
  import dlr_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic      cfg_index;
  logic [7:0] cfg_data;

  delimited_line_receiver DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [7:0]       line_mem [BUF_SIZE];
  logic [CNT_W-1:0] fill_cnt;
  logic             line_held;
  logic [7:0]       start_c;
  logic [7:0]       end_c;

  out_item_t results_due[$];
  int        fail_count = 0;
  int        idle_cycles;
  bit        gaps_on;
  bit        stalls_on;
  int        stall_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_result(logic kind, logic [7:0] value, logic last);
    out_item_t res;
    res.kind = kind;
    res.value = value;
    res.last = last;
    res.line_pending = line_held;
    results_due.push_back(res);
  endtask

  task automatic model_request(in_item_t req);
    bit handover;
    int len;
    logic [7:0] b;
    handover = 0;
    len = 0;
    b = req.rx_byte;
    if (req.cmd == CMD_RELEASE) begin
      line_held = 1'b0;
      return;
    end
    if (b == start_c) begin
      fill_cnt = '0;
    end else if (b == end_c) begin
      if (fill_cnt < BUF_SIZE && !line_held) begin
        handover = 1;
        while (len < fill_cnt && line_mem[len] != 8'h00) len++;
        line_held = 1'b1;
      end
      fill_cnt = '0;
    end else if (fill_cnt < BUF_SIZE - 1) begin
      line_mem[fill_cnt] = b;
      fill_cnt = fill_cnt + 1'b1;
    end
    push_result(KIND_ECHO, b, !handover);
    if (handover) begin
      for (int i = 0; i < len; i++) push_result(KIND_LINE, line_mem[i], 1'b0);
      push_result(KIND_LINE, 8'h00, 1'b1);
    end
  endtask

  task automatic send_request(logic cmd, logic [7:0] b);
    in_item_t req;
    int gap;
    req.cmd = cmd;
    req.rx_byte = b;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    model_request(req);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_request(CMD_BYTE, b);
  endtask

  task automatic send_release();
    send_request(CMD_RELEASE, 8'($urandom_range(0, 255)));
  endtask

  // Drop valid, drain every expected result, then let queued releases settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_START_CHAR) start_c = val;
    else end_c = val;
  endtask

  task automatic set_delims(logic [7:0] s, logic [7:0] e);
    wait_idle();
    write_reg(REG_START_CHAR, s);
    write_reg(REG_END_CHAR, e);
  endtask

  function automatic logic [7:0] pick_content(bit allow_zero);
    logic [7:0] b;
    do begin
      b = (allow_zero && $urandom_range(0, 11) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    end while (b == start_c || b == end_c);
    return b;
  endfunction

  task automatic send_line(int len, bit allow_zero, bit with_start, bit with_release,
                           inout int sent);
    if (with_start) begin
      send_byte(start_c);
      sent++;
    end
    for (int i = 0; i < len; i++) begin
      send_byte(pick_content(allow_zero));
      sent++;
    end
    send_byte(end_c);
    sent++;
    if (with_release) begin
      send_release();
      sent++;
    end
  endtask

  task automatic test_basic_line();
    send_byte(8'h2A);
    send_byte(8'h48);
    send_byte(8'hFF);
    send_byte(8'h0D);
    send_release();
  endtask

  task automatic test_pending_drop();
    send_byte(8'h2A);
    send_byte(8'h61);
    send_byte(8'h0D);
    send_byte(8'h62);
    send_byte(8'h0D);
    // hold the sender until the whole line is out
    wait_idle();
    send_release();
  endtask

  task automatic test_zero_in_line();
    send_byte(8'h2A);
    send_byte(8'h78);
    send_byte(8'h00);
    send_byte(8'h79);
    send_byte(8'h0D);
    send_release();
  endtask

  task automatic test_delimiters();
    set_delims(8'h55, 8'h55);
    send_byte(8'h71);
    send_byte(8'h55);
    set_delims(8'h00, 8'hFF);
    send_byte(8'hFF);
    send_release();
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_release();
  endtask

  task automatic test_random_lines();
    logic [7:0] phase_s [5];
    logic [7:0] phase_e [5];
    int sent;
    int len;
    phase_s = '{START_CHAR_RESET, 8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'h3A};
    phase_e = '{END_CHAR_RESET, 8'hFF, 8'h00, 8'($urandom_range(0, 255)), 8'h3A};
    for (int p = 0; p < 5; p++) begin
      set_delims(phase_s[p], phase_e[p]);
      sent = 0;
      if (p == 0) begin
        // overfill the store, then a full-length hand-over
        send_line(36, 1'b0, 1'b1, 1'b1, sent);
      end
      while (sent < 8) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 3) != 0) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 8);
          send_line(len, 1'b1, $urandom_range(0, 9) != 0, $urandom_range(0, 4) != 0, sent);
        end else if ($urandom_range(0, 2) != 0) begin
          send_byte(8'($urandom_range(0, 255)));
          sent++;
        end else begin
          send_release();
          sent++;
        end
      end
    end
    gaps_on = 1;
    stalls_on = 1;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: kind %0d value %0h", out_data.kind, out_data.value);
        fail_count++;
      end else begin
        out_item_t exp;
        exp = results_due.pop_front();
        if (out_data.kind !== exp.kind) begin
          $error("kind: expected %0d, got %0d", exp.kind, out_data.kind);
          fail_count++;
        end
        if (out_data.value !== exp.value) begin
          $error("value: expected %0h, got %0h", exp.value, out_data.value);
          fail_count++;
        end
        if (out_data.last !== exp.last) begin
          $error("last: expected %0d, got %0d", exp.last, out_data.last);
          fail_count++;
        end
        if (out_data.line_pending !== exp.line_pending) begin
          $error("line_pending: expected %0d, got %0d", exp.line_pending,
                 out_data.line_pending);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (stalls_on) stall_left = pick_gap();
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_START_CHAR;
    cfg_data = 8'h00;
    gaps_on = 1;
    stalls_on = 1;
    fill_cnt = '0;
    line_held = 1'b0;
    start_c = START_CHAR_RESET;
    end_c = END_CHAR_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_line();
    test_pending_drop();
    test_zero_in_line();
    test_delimiters();
    test_random_lines();

    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
